FILE: rtl/utf16_to_utf8_lenient_transcoder_assert.svh
// assertion macros for the transcoder
`ifndef UTF16_TO_UTF8_LENIENT_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_LENIENT_TRANSCODER_ASSERT_SVH

// same-cycle implication
`define U16U8_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define U16U8_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/u16u8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

    localparam logic [20:0] REPL_CP = 21'h00FFFD;
    localparam logic [7:0]  REPL_B0 = 8'hEF;
    localparam logic [7:0]  REPL_B1 = 8'hBF;
    localparam logic [7:0]  REPL_B2 = 8'hBD;
    localparam logic [5:0]  LEAD_TAG  = 6'b110110;
    localparam logic [5:0]  TRAIL_TAG = 6'b110111;
    localparam int unsigned MAX_BYTES = 6;

    typedef logic [3:0][7:0] enc_bytes_t;
    typedef logic [5:0][7:0] run_bytes_t;

    typedef struct packed {
        enc_bytes_t  bytes;
        logic [2:0]  cnt;
    } enc_t;

    typedef struct packed {
        logic        pend;
        logic [9:0]  held;
        logic [15:0] pos;
        logic [15:0] prev_pos;
    } unit_state_t;

    typedef struct packed {
        run_bytes_t  bytes;
        logic [2:0]  cnt;
        logic        hold;
        logic [9:0]  held_bits;
        logic        mark;
        logic [15:0] mark_pos;
    } step_t;

    function automatic enc_t encode_cp(input logic [20:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp < 21'h80) begin
            e.cnt = 3'd1;
            e.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            e.cnt = 3'd2;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            e.cnt = 3'd3;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            e.cnt = 3'd4;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/utf16_to_utf8_lenient_transcoder.sv
// the first byte of a unit is registered and valid in the cycle after the unit is accepted
// a unit yields n bytes (0 to 6); the 6-byte output shift buffer sets the rate:
// a new unit is taken with the last byte of the one before, or when the buffer is empty
// reset: aresetn low at a clock edge clears the held lead, position and error record
// and empties the output buffer
`timescale 1ns / 1ps
`default_nettype none

`include "utf16_to_utf8_lenient_transcoder_assert.svh"

module utf16_to_utf8_lenient_transcoder #(
    parameter longint unsigned MAX_UNITS = 64'd65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_code_unit,
    input  wire logic        s_last_unit,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last_of_run,
    output logic             m_end_of_text,
    output logic             m_any_invalid,
    output logic [15:0]      m_first_invalid_index
);

    localparam logic [15:0] POS_LAST =
        16'((MAX_UNITS < 64'd65536) ? (MAX_UNITS - 64'd1) : 64'd65535);

    logic                   pend_reg, pend_next;
    logic [9:0]             held_reg, held_next;
    logic [15:0]            pos_reg, pos_next;
    logic                   inv_reg, inv_next;
    logic [15:0]            bad_reg, bad_next;

    u16u8_pkg::run_bytes_t  buf_reg, buf_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic                   eot_reg, eot_next;
    logic                   any_reg, any_next;
    logic [15:0]            idx_reg, idx_next;

    u16u8_pkg::unit_state_t st;
    u16u8_pkg::step_t       step;
    logic                   s_fire;
    logic                   m_fire;
    logic                   inv_after;
    logic [15:0]            bad_after;

    assign st.pend     = pend_reg;
    assign st.held     = held_reg;
    assign st.pos      = pos_reg;
    assign st.prev_pos = (pos_reg == 16'd0) ? POS_LAST : pos_reg - 16'd1;

    u16u8_step u_step (
        .code_unit (s_code_unit),
        .last_unit (s_last_unit),
        .st        (st),
        .res       (step)
    );

    assign m_valid = cnt_reg != 3'd0;
    assign m_fire  = m_valid && m_ready;
    assign s_ready = !m_valid || (m_ready && cnt_reg == 3'd1);
    assign s_fire  = s_valid && s_ready;

    assign inv_after = inv_reg || step.mark;
    assign bad_after = inv_reg ? bad_reg : step.mark_pos;

    assign m_out_byte            = buf_reg[0];
    assign m_last_of_run         = cnt_reg == 3'd1;
    assign m_end_of_text         = (cnt_reg == 3'd1) && eot_reg;
    assign m_any_invalid         = any_reg;
    assign m_first_invalid_index = idx_reg;

    always_comb begin
        pend_next = pend_reg;
        held_next = held_reg;
        pos_next  = pos_reg;
        inv_next  = inv_reg;
        bad_next  = bad_reg;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        eot_next  = eot_reg;
        any_next  = any_reg;
        idx_next  = idx_reg;

        if (m_fire) begin
            buf_next = {8'd0, buf_reg[5:1]};
            cnt_next = cnt_reg - 3'd1;
        end

        if (s_fire) begin
            buf_next = step.bytes;
            cnt_next = step.cnt;
            eot_next = s_last_unit;
            any_next = inv_after;
            idx_next = inv_after ? bad_after : 16'd0;

            if (s_last_unit) begin
                pend_next = 1'b0;
                held_next = '0;
                pos_next  = '0;
                inv_next  = 1'b0;
                bad_next  = '0;
            end else begin
                pend_next = step.hold;
                if (step.hold) begin
                    held_next = step.held_bits;
                end
                pos_next = (pos_reg == POS_LAST) ? 16'd0 : pos_reg + 16'd1;
                inv_next = inv_after;
                bad_next = bad_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            held_reg <= '0;
            pos_reg  <= '0;
            inv_reg  <= 1'b0;
            bad_reg  <= '0;
            cnt_reg  <= '0;
        end else begin
            pend_reg <= pend_next;
            held_reg <= held_next;
            pos_reg  <= pos_next;
            inv_reg  <= inv_next;
            bad_reg  <= bad_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
        eot_reg <= eot_next;
        any_reg <= any_next;
        idx_reg <= idx_next;
    end

    `U16U8_ASSERT_NOW(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= 3'(u16u8_pkg::MAX_BYTES))
    `U16U8_ASSERT_NOW(a_clean_index, aclk, aresetn, m_valid && !m_any_invalid, m_first_invalid_index == 16'd0)
    `U16U8_ASSERT_NEXT(a_text_end_clears, aclk, aresetn, s_fire && s_last_unit, !pend_reg && !inv_reg && pos_reg == 16'd0)
    `U16U8_ASSERT_NEXT(a_hold_silent, aclk, aresetn, s_fire && step.hold && !pend_reg, !m_valid)

endmodule

`default_nettype wire

FILE: rtl/u16u8_step.sv
`timescale 1ns / 1ps
`default_nettype none

module u16u8_step (
    input  wire logic [15:0]           code_unit,
    input  wire logic                  last_unit,
    input  wire u16u8_pkg::unit_state_t st,
    output u16u8_pkg::step_t           res
);

    logic                is_lead;
    logic                is_trail;
    logic                pair;
    logic                pre;
    logic                own_bad;
    logic                hold;
    logic [20:0]         pair_cp;
    logic [20:0]         cp_main;
    u16u8_pkg::enc_t     e_main;
    logic [2:0]          main_cnt;

    assign is_lead  = code_unit[15:10] == u16u8_pkg::LEAD_TAG;
    assign is_trail = code_unit[15:10] == u16u8_pkg::TRAIL_TAG;
    assign pair     = st.pend && is_trail;
    assign pre      = st.pend && !is_trail;
    assign own_bad  = !pair && ((is_lead && last_unit) || is_trail);
    assign hold     = !pair && is_lead && !last_unit;
    assign pair_cp  = 21'h010000 + {1'b0, st.held, code_unit[9:0]};

    always_comb begin
        if (pair) begin
            cp_main = pair_cp;
        end else if (own_bad) begin
            cp_main = u16u8_pkg::REPL_CP;
        end else begin
            cp_main = {5'd0, code_unit};
        end
        e_main   = u16u8_pkg::encode_cp(cp_main);
        main_cnt = hold ? 3'd0 : e_main.cnt;

        if (pre) begin
            res.bytes = {e_main.bytes[2], e_main.bytes[1], e_main.bytes[0],
                         u16u8_pkg::REPL_B2, u16u8_pkg::REPL_B1, u16u8_pkg::REPL_B0};
            res.cnt   = main_cnt + 3'd3;
        end else begin
            res.bytes = {16'd0, e_main.bytes};
            res.cnt   = main_cnt;
        end

        res.hold      = hold;
        res.held_bits = code_unit[9:0];
        res.mark      = pre || own_bad;
        res.mark_pos  = pre ? st.prev_pos : st.pos;
    end

endmodule

`default_nettype wire
